// ----- rtl/sorted_key_index_core_defines.svh -----
// shared assertion macros for the sorted key index core
`ifndef SORTED_KEY_INDEX_CORE_DEFINES_SVH
`define SORTED_KEY_INDEX_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SKI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted key index: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SKI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted key index: next-cycle check failed");

`endif

// ----- rtl/ski_pkg.sv -----
package ski_pkg;

    localparam int KEY_W  = 32;
    localparam int OFF_W  = 8;
    localparam int STAT_W = 3;

    // request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_PLACE,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  offset;
    } t_out_word;

    // one table entry as held in memory
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [OFF_W-1:0]        offset;
    } t_entry;

endpackage

// ----- rtl/ski_ram.sv -----
module ski_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ski_seq.sv -----
`include "sorted_key_index_core_defines.svh"

module ski_seq #(
    parameter int CAPACITY = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ski_pkg::t_in_word             i_in_word,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output ski_pkg::t_out_word            o_res_word,
    output logic                          o_mem_we,
    output logic [$clog2(CAPACITY)-1:0]   o_mem_waddr,
    output ski_pkg::t_entry               o_mem_wdata,
    output logic                          o_mem_re,
    output logic [$clog2(CAPACITY)-1:0]   o_mem_raddr,
    input  ski_pkg::t_entry               i_mem_rdata
);

    import ski_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state                  r_state, n_state;
    logic                    r_mode, n_mode;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_pos, n_pos;
    logic                    r_pend, n_pend;
    logic [AW-1:0]           r_wa, n_wa;
    logic [STAT_W-1:0]       r_status, n_status;
    logic [OFF_W-1:0]        r_off, n_off;

    logic [CW-1:0]           idx_m1;
    logic [CW+OFF_W-1:0]     pos_ext;
    logic [OFF_W-1:0]        off_sat;
    logic                    scan_ge;
    logic                    scan_eq;

    // rank saturates at the top of the offset field
    assign pos_ext = {{OFF_W{1'b0}}, r_pos};
    assign off_sat = (|pos_ext[CW+OFF_W-1:OFF_W]) ? {OFF_W{1'b1}} : pos_ext[OFF_W-1:0];

    assign idx_m1  = r_idx - 1'b1;
    assign scan_ge = $signed(i_mem_rdata.key) >= $signed(r_key);
    assign scan_eq = i_mem_rdata.key == r_key;

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_wa     <= n_wa;
        r_status <= n_status;
        r_off    <= n_off;
    end

    // next state, memory requests
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_key    = r_key;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_pend   = r_pend;
        n_wa     = r_wa;
        n_status = r_status;
        n_off    = r_off;

        o_mem_we    = 1'b0;
        o_mem_waddr = r_pos[AW-1:0];
        o_mem_wdata = '{key: r_key, offset: off_sat};
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_in_word.mode;
                    n_key   = i_in_word.key;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = ST_SCAN;
                end
            end

            // upward scan, one read per cycle, each compare on the word read in the cycle before
            ST_SCAN: begin
                if ((r_pend && scan_ge) || (r_idx == r_count)) begin
                    n_pend = 1'b0;
                    n_off  = '0;
                    if (r_pend && scan_ge) begin
                        n_pos = idx_m1;
                    end else begin
                        n_pos = r_count;
                    end
                    n_idx = r_count;
                    if (r_mode == MODE_LOOKUP) begin
                        n_state = ST_RESULT;
                        if (r_pend && scan_ge && scan_eq) begin
                            n_status = STAT_FOUND;
                            n_off    = i_mem_rdata.offset;
                        end else begin
                            n_status = STAT_NOT_FOUND;
                        end
                    end else if (r_pend && scan_ge && scan_eq) begin
                        n_status = STAT_DUPLICATE;
                        n_state  = ST_RESULT;
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_status = STAT_FULL;
                        n_state  = ST_RESULT;
                    end else begin
                        n_state = ST_SHIFT;
                    end
                end else begin
                    o_mem_re = 1'b1;
                    n_idx    = r_idx + 1'b1;
                    n_pend   = 1'b1;
                end
            end

            // move entries above the slot up by one, top first
            ST_SHIFT: begin
                if (r_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_wa;
                    o_mem_wdata = i_mem_rdata;
                end
                if (r_idx == r_pos) begin
                    n_pend  = 1'b0;
                    n_state = ST_PLACE;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = idx_m1[AW-1:0];
                    n_wa        = r_idx[AW-1:0];
                    n_idx       = idx_m1;
                    n_pend      = 1'b1;
                end
            end

            // write the new key into the freed slot
            ST_PLACE: begin
                o_mem_we = 1'b1;
                n_count  = r_count + 1'b1;
                n_status = STAT_INSERTED;
                n_off    = off_sat;
                n_state  = ST_RESULT;
            end

            ST_RESULT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_res_valid = r_state == ST_RESULT;
    assign o_res_word  = '{status: r_status, offset: r_off};

    // table never overflows
    `SKI_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    // scan never writes the table
    `SKI_ASSERT_IMP(a_scan_no_write, i_clk, i_rst_n, r_state == ST_SCAN, !o_mem_we)
    // shift writes only above the insertion slot
    `SKI_ASSERT_IMP(a_shift_above_pos, i_clk, i_rst_n, (r_state == ST_SHIFT) && o_mem_we, CW'(o_mem_waddr) > r_pos)
    // count grows by one exactly after a placement
    `SKI_ASSERT_NXT(a_count_inc, i_clk, i_rst_n, r_state == ST_PLACE, r_count == $past(r_count) + 1'b1)
    `SKI_ASSERT_NXT(a_count_hold, i_clk, i_rst_n, r_state != ST_PLACE, $stable(r_count))

endmodule

// ----- rtl/sorted_key_index_core.sv -----
// Sorted key index: keeps up to CAPACITY unique signed 32-bit keys in ascending order in
// one synchronous memory, each with the rank it had when inserted. One word is processed
// at a time. An insert scans upward from the lowest key until it reaches the first key not
// below the new one, then moves every larger entry up one slot, top first, and writes the
// new entry, moving one entry at a time through the single read and single write port
// of the table memory. A lookup or a rejected insert stops at the scan. Duplicate keys
// are rejected even when the table is full. The result sits in an output register, so
// the next word can be taken while it waits.
module sorted_key_index_core #(
    parameter int CAPACITY = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ski_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output ski_pkg::t_out_word o_data
);

    import ski_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;

    logic          res_valid;
    logic          res_ready;
    t_out_word     res_word;

    logic          r_out_valid;
    t_out_word     r_out_word;

    // table memory
    ski_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // scan and shift sequencer
    ski_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_in_word   (i_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_word  (res_word),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // output register
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_word <= res_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_word;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import ski_pkg::*;

    localparam int CAPACITY   = 256;
    localparam int RAND_WORDS = 1050;
    localparam int MAX_GAP    = 18;
    // slowest word: full scan and shift plus both stalls, taken many times over
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 300;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_data;

    // mirror of the sorted table
    logic signed [KEY_W-1:0] tbl_key [CAPACITY];
    logic [OFF_W-1:0]        tbl_off [CAPACITY];
    int unsigned             tbl_count = 0;

    t_out_word   pending_answers [$];
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;
    bit          steady = 1'b0;

    sorted_key_index_core #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // answer for one word, updating the mirrored table
    function automatic t_out_word predict_answer(t_in_word w);
        logic signed [KEY_W-1:0] k;
        int unsigned pos;
        bit hit;
        t_out_word ans;
        k = w.key;
        pos = 0;
        ans.status = STAT_NOT_FOUND;
        ans.offset = '0;
        while (pos < tbl_count && tbl_key[pos] < k) pos++;
        hit = (pos < tbl_count) && (tbl_key[pos] == k);
        if (w.mode == MODE_LOOKUP) begin
            if (hit) begin
                ans.status = STAT_FOUND;
                ans.offset = tbl_off[pos];
            end
        end else if (hit) begin
            ans.status = STAT_DUPLICATE;
        end else if (tbl_count >= CAPACITY) begin
            ans.status = STAT_FULL;
        end else begin
            for (int unsigned j = tbl_count; j > pos; j--) begin
                tbl_key[j] = tbl_key[j-1];
                tbl_off[j] = tbl_off[j-1];
            end
            ans.status = STAT_INSERTED;
            ans.offset = (pos > 255) ? 8'd255 : OFF_W'(pos);
            tbl_key[pos] = k;
            tbl_off[pos] = ans.offset;
            tbl_count++;
        end
        return ans;
    endfunction

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // key spread over the full range, near zero and near both ends
    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            6, 7:    return int'($urandom_range(0, 200)) - 100;
            8:       return KEY_MIN + int'($urandom_range(0, 15));
            9:       return KEY_MAX - int'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [KEY_W-1:0] stored_key();
        return tbl_key[$urandom_range(0, tbl_count - 1)];
    endfunction

    // one word into the block, predicted when accepted
    task automatic send_word(input logic mode, input logic signed [KEY_W-1:0] key);
        int unsigned gap;
        t_in_word w;
        w.mode = mode;
        w.key = key;
        if ($urandom_range(0, 39) == 0) steady = !steady;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        pending_answers.push_back(predict_answer(w));
    endtask

    // lookups on a table that holds nothing yet
    task automatic test_empty_lookup();
        send_word(MODE_LOOKUP, '0);
        send_word(MODE_LOOKUP, KEY_MIN);
        send_word(MODE_LOOKUP, KEY_MAX);
    endtask

    // extreme keys, sign boundary, duplicates and misses next to stored keys
    task automatic test_extremes();
        send_word(MODE_INSERT, KEY_MAX);
        send_word(MODE_INSERT, KEY_MIN);
        send_word(MODE_INSERT, '0);
        send_word(MODE_INSERT, -1);
        send_word(MODE_INSERT, 1);
        send_word(MODE_INSERT, KEY_MAX - 1);
        send_word(MODE_INSERT, KEY_MIN + 1);
        send_word(MODE_INSERT, KEY_MAX);
        send_word(MODE_INSERT, KEY_MIN);
        send_word(MODE_INSERT, 0);
        send_word(MODE_LOOKUP, KEY_MAX);
        send_word(MODE_LOOKUP, KEY_MIN);
        send_word(MODE_LOOKUP, -1);
        send_word(MODE_LOOKUP, 1);
        send_word(MODE_LOOKUP, 2);
        send_word(MODE_LOOKUP, -2);
        send_word(MODE_LOOKUP, KEY_MAX - 2);
        send_word(MODE_LOOKUP, 32'sh5555_AAAA);
    endtask

    // mixed inserts and lookups, the table fills partway through
    task automatic test_random_mix();
        int unsigned r;
        for (int n = 0; n < RAND_WORDS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45 || tbl_count == 0) begin
                send_word(MODE_INSERT, pick_key());
            end else if (r < 60) begin
                send_word(MODE_INSERT, stored_key());
            end else if (r < 85) begin
                send_word(MODE_LOOKUP, stored_key());
            end else begin
                send_word(MODE_LOOKUP, pick_key());
            end
        end
    endtask

    // full table: new keys rejected, duplicates still reported as such
    task automatic test_full_table();
        while (tbl_count < CAPACITY) send_word(MODE_INSERT, pick_key());
        for (int n = 0; n < 12; n++) begin
            send_word(MODE_INSERT, pick_key());
            send_word(MODE_INSERT, stored_key());
            send_word(MODE_LOOKUP, stored_key());
        end
        send_word(MODE_LOOKUP, tbl_key[0]);
        send_word(MODE_LOOKUP, tbl_key[CAPACITY-1]);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_lookup();
        test_extremes();
        test_random_mix();
        test_full_table();
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // result side: random stall per word, compare with the oldest answer
    initial begin
        t_out_word want;
        int unsigned gap;
        wait (i_rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            if (pending_answers.size() == 0) begin
                $error("result word with no answer pending: status %0d offset %0d",
                       o_data.status, o_data.offset);
                mismatch_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_data.status);
                    mismatch_count++;
                end
                if (o_data.offset !== want.offset) begin
                    $error("offset: expected %0d, actual %0d", want.offset, o_data.offset);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ski_pkg.sv
rtl/ski_ram.sv
rtl/ski_seq.sv
rtl/sorted_key_index_core.sv
tb/tb.sv
